// ===== src/m65_pkg.sv =====
`default_nettype none

package m65_pkg;

   localparam logic [4:0] OP_ADC  = 5'd0;
   localparam logic [4:0] OP_AND  = 5'd1;
   localparam logic [4:0] OP_ASL  = 5'd2;
   localparam logic [4:0] OP_BCC  = 5'd3;
   localparam logic [4:0] OP_BCS  = 5'd4;
   localparam logic [4:0] OP_BEQ  = 5'd5;
   localparam logic [4:0] OP_BMI  = 5'd6;
   localparam logic [4:0] OP_BNE  = 5'd7;
   localparam logic [4:0] OP_BPL  = 5'd8;
   localparam logic [4:0] OP_BVC  = 5'd9;
   localparam logic [4:0] OP_BVS  = 5'd10;
   localparam logic [4:0] OP_CLC  = 5'd11;
   localparam logic [4:0] OP_CLD  = 5'd12;
   localparam logic [4:0] OP_CLI  = 5'd13;
   localparam logic [4:0] OP_CLV  = 5'd14;
   localparam logic [4:0] OP_PHA  = 5'd15;
   localparam logic [4:0] OP_PLA  = 5'd16;
   localparam logic [4:0] OP_PLP  = 5'd17;
   localparam logic [4:0] OP_SBC  = 5'd18;
   localparam logic [4:0] OP_SEC  = 5'd19;
   localparam logic [4:0] OP_SED  = 5'd20;
   localparam logic [4:0] OP_SEI  = 5'd21;
   localparam logic [4:0] OP_STA  = 5'd22;
   localparam logic [4:0] OP_STX  = 5'd23;
   localparam logic [4:0] OP_STY  = 5'd24;
   localparam logic [4:0] OP_TAX  = 5'd25;
   localparam logic [4:0] OP_TAY  = 5'd26;
   localparam logic [4:0] OP_TSX  = 5'd27;
   localparam logic [4:0] OP_TXA  = 5'd28;
   localparam logic [4:0] OP_TXS  = 5'd29;
   localparam logic [4:0] OP_TYA  = 5'd30;
   localparam logic [4:0] OP_NONE = 5'd31;

   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_U = 5;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   localparam logic [15:0] PAGE_MASK = 16'hFF00;

   typedef struct packed {
      logic [4:0]        op;
      logic [7:0]        operand;
      logic              accumulator_mode;
      logic [15:0]       target_address;
      logic signed [7:0] branch_offset;
      logic [15:0]       current_pc;
   } req_type;

   typedef struct packed {
      logic [7:0]  acc_out;
      logic [7:0]  x_out;
      logic [7:0]  y_out;
      logic [7:0]  sp_out;
      logic [7:0]  status_out;
      logic [15:0] next_pc;
      logic        mem_write;
      logic [15:0] mem_address;
      logic [7:0]  mem_data;
      logic [1:0]  extra_cycles;
      logic        may_add_cycle;
   } rsp_type;

   typedef struct packed {
      logic [7:0] a;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] sp;
      logic [7:0] p;
   } regs_type;

   function automatic logic [7:0] put_zn(input logic [7:0] p, input logic [7:0] v);
      logic [7:0] r;
      r = p;
      r[FLAG_Z] = (v == 8'd0);
      r[FLAG_N] = v[7];
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/mos6502_execute_subset.sv =====
// channel   ports                               transfer when
// -------   ---------------------------------   ------------------------
// request   req_valid, req_ready, req_data      req_valid && req_ready
// response  rsp_valid, rsp_ready, rsp_data      rsp_valid && rsp_ready
//
// one instruction per cycle sustained while the response side keeps up:
// the stack read is issued and the request is registered as it transfers;
// execution then loads the register file and the response register together.
// a pull right behind a push of the same slot takes the pushed byte by bypass.
// reset clears the register file, the valid flags and the stack valid bits; no clearing pass.
// a stalled response holds execution; the request side then stops too.
`default_nettype none

module mos6502_execute_subset
   import m65_pkg::*;
#(
   parameter int STACK_DEPTH = 256
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int AW = $clog2(STACK_DEPTH);

   function automatic logic [256*AW-1:0] build_mod_table();
      logic [256*AW-1:0] t;
      t = '0;
      for (int i = 0; i < 256; i++) begin
         t[i*AW +: AW] = AW'(i % STACK_DEPTH);
      end
      return t;
   endfunction

   localparam logic [256*AW-1:0] MOD_TABLE = build_mod_table();

   regs_type         regs_ff, regs_in;
   logic             s1_valid_ff;
   req_type          s1_req_ff;
   logic             s1_byp_ff, s1_byp_in;
   logic [7:0]       s1_byp_data_ff;
   logic             s1_vld_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic [STACK_DEPTH-1:0] vld_ff;

   logic             s1_adv, accept;
   logic [7:0]       sp_fwd, rd_sp;
   logic [AW-1:0]    rd_addr, wr_addr;
   logic             wr_en;
   logic [7:0]       ram_q, pull_data;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   assign sp_fwd  = s1_adv ? regs_in.sp : regs_ff.sp;
   assign rd_sp   = sp_fwd + 8'd1;
   assign rd_addr = MOD_TABLE[rd_sp*AW +: AW];
   assign wr_addr = MOD_TABLE[regs_ff.sp*AW +: AW];
   assign wr_en   = s1_adv && (s1_req_ff.op == OP_PHA);

   assign s1_byp_in = wr_en && (wr_addr == rd_addr);
   assign pull_data = s1_byp_ff ? s1_byp_data_ff : (s1_vld_ff ? ram_q : 8'd0);

   m65_ram #(
      .WIDTH (8),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (regs_ff.a),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   m65_alu u_alu (
      .regs_in   (regs_ff),
      .req       (s1_req_ff),
      .pull_data (pull_data),
      .regs_out  (regs_in),
      .rsp       (rsp_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s1_byp_ff    <= 1'b0;
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
      end else begin
         if (s1_adv) begin
            regs_ff <= regs_in;
         end
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
            s1_byp_ff   <= s1_byp_in;
            s1_vld_ff   <= vld_ff[rd_addr];
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff      <= req_data;
         s1_byp_data_ff <= regs_ff.a;
      end
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_adv_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("executed instruction did not reach the response register");

   a_stall_holds_regs: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> $stable(regs_ff))
      else $error("registers changed while execution was stalled");

   a_push_marks_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> vld_ff[$past(wr_addr)])
      else $error("pushed stack slot not marked valid");
`endif

endmodule

`default_nettype wire

// ===== src/m65_ram.sv =====
`default_nettype none

module m65_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/m65_alu.sv =====
`default_nettype none

module m65_alu
   import m65_pkg::*;
(
   input  wire regs_type   regs_in,
   input  wire req_type    req,
   input  wire logic [7:0] pull_data,
   output regs_type        regs_out,
   output rsp_type         rsp
);

   logic [7:0]  add_m;
   logic [8:0]  sum;
   logic [7:0]  shl;
   logic [15:0] target;
   logic        take;

   assign add_m  = (req.op == OP_SBC) ? ~req.operand : req.operand;
   assign sum    = {1'b0, regs_in.a} + {1'b0, add_m} + {8'd0, regs_in.p[FLAG_C]};
   assign shl    = {req.operand[6:0], 1'b0};
   assign target = req.current_pc + {{8{req.branch_offset[7]}}, req.branch_offset};

   always_comb begin
      regs_out = regs_in;
      take     = 1'b0;
      rsp      = '0;
      unique case (req.op) inside
         OP_ADC, OP_SBC: begin
            regs_out.a         = sum[7:0];
            regs_out.p[FLAG_C] = sum[8];
            regs_out.p[FLAG_V] = ~(regs_in.a[7] ^ add_m[7]) & (regs_in.a[7] ^ sum[7]);
            regs_out.p         = put_zn(regs_out.p, sum[7:0]);
            rsp.may_add_cycle  = 1'b1;
         end
         OP_AND: begin
            regs_out.a        = regs_in.a & req.operand;
            regs_out.p        = put_zn(regs_in.p, regs_in.a & req.operand);
            rsp.may_add_cycle = 1'b1;
         end
         OP_ASL: begin
            regs_out.p[FLAG_C] = req.operand[7];
            regs_out.p         = put_zn(regs_out.p, shl);
            if (req.accumulator_mode) begin
               regs_out.a = shl;
            end else begin
               rsp.mem_write   = 1'b1;
               rsp.mem_address = req.target_address;
               rsp.mem_data    = shl;
            end
         end
         OP_BCC: take = ~regs_in.p[FLAG_C];
         OP_BCS: take = regs_in.p[FLAG_C];
         OP_BEQ: take = regs_in.p[FLAG_Z];
         OP_BMI: take = regs_in.p[FLAG_N];
         OP_BNE: take = ~regs_in.p[FLAG_Z];
         OP_BPL: take = ~regs_in.p[FLAG_N];
         OP_BVC: take = ~regs_in.p[FLAG_V];
         OP_BVS: take = regs_in.p[FLAG_V];
         OP_CLC: regs_out.p[FLAG_C] = 1'b0;
         OP_CLD: regs_out.p[FLAG_D] = 1'b0;
         OP_CLI: regs_out.p[FLAG_I] = 1'b0;
         OP_CLV: regs_out.p[FLAG_V] = 1'b0;
         OP_PHA: regs_out.sp = regs_in.sp - 8'd1;
         OP_PLA: begin
            regs_out.sp = regs_in.sp + 8'd1;
            regs_out.a  = pull_data;
            regs_out.p  = put_zn(regs_in.p, pull_data);
         end
         OP_PLP: begin
            regs_out.sp        = regs_in.sp + 8'd1;
            regs_out.p         = pull_data;
            regs_out.p[FLAG_U] = 1'b1;
         end
         OP_SEC: regs_out.p[FLAG_C] = 1'b1;
         OP_SED: regs_out.p[FLAG_D] = 1'b1;
         OP_SEI: regs_out.p[FLAG_I] = 1'b1;
         OP_STA, OP_STX, OP_STY: begin
            rsp.mem_write   = 1'b1;
            rsp.mem_address = req.target_address;
            rsp.mem_data    = (req.op == OP_STA) ? regs_in.a :
                              (req.op == OP_STX) ? regs_in.x : regs_in.y;
         end
         OP_TAX: begin
            regs_out.x = regs_in.a;
            regs_out.p = put_zn(regs_in.p, regs_in.a);
         end
         OP_TAY: begin
            regs_out.y = regs_in.a;
            regs_out.p = put_zn(regs_in.p, regs_in.a);
         end
         OP_TSX: begin
            regs_out.x = regs_in.sp;
            regs_out.p = put_zn(regs_in.p, regs_in.sp);
         end
         OP_TXA: begin
            regs_out.a = regs_in.x;
            regs_out.p = put_zn(regs_in.p, regs_in.x);
         end
         OP_TXS: regs_out.sp = regs_in.x;
         OP_TYA: begin
            regs_out.a = regs_in.y;
            regs_out.p = put_zn(regs_in.p, regs_in.y);
         end
         OP_NONE: ;
         default: ;
      endcase

      rsp.acc_out    = regs_out.a;
      rsp.x_out      = regs_out.x;
      rsp.y_out      = regs_out.y;
      rsp.sp_out     = regs_out.sp;
      rsp.status_out = regs_out.p;
      rsp.next_pc    = take ? target : req.current_pc;
      if (take) begin
         rsp.extra_cycles = ((target & PAGE_MASK) != (req.current_pc & PAGE_MASK)) ?
                            2'd2 : 2'd1;
      end
   end

endmodule

`default_nettype wire

// ===== sim/mos6502_execute_subset_test.sv =====
`default_nettype none

module mos6502_execute_subset_test;
   import m65_pkg::*;

   localparam int RANDOM_ITEMS = 1900;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      req_type req;
      logic    typed;
      rsp_type want;
   } table_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // architectural copy kept alongside the block
   logic [7:0] a_reg, x_reg, y_reg, sp_reg, p_reg;
   logic [7:0] stack_mem [0:255];

   rsp_type predicted_regs_q [$];
   table_row_type stim_table [$];

   int cycle_count = 0;
   int fail_count = 0;
   int results_checked = 0;
   int items_sent = 0;
   int taken_branches = 0;
   int mem_writes = 0;
   int burst_left = 0;
   int ready_mode = 0;
   int ready_mode_left = 0;

   mos6502_execute_subset DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic req_type instr(input logic [4:0] op, input logic [7:0] operand,
                                     input logic mode, input logic [15:0] addr,
                                     input logic [7:0] offset, input logic [15:0] pc);
      req_type r;
      r.op = op;
      r.operand = operand;
      r.accumulator_mode = mode;
      r.target_address = addr;
      r.branch_offset = offset;
      r.current_pc = pc;
      return r;
   endfunction

   function automatic void set_zn(input logic [7:0] v);
      p_reg[FLAG_Z] = (v == 8'h00);
      p_reg[FLAG_N] = v[7];
   endfunction

   function automatic rsp_type execute_instr(input req_type r);
      rsp_type    o;
      logic [7:0] m;
      logic [7:0] res;
      logic [8:0] sum;
      logic [15:0] tgt;
      logic       take;
      o = '0;
      o.next_pc = r.current_pc;
      take = 1'b0;
      case (r.op) inside
         OP_ADC, OP_SBC: begin
            m = (r.op == OP_SBC) ? ~r.operand : r.operand;
            sum = {1'b0, a_reg} + {1'b0, m} + {8'd0, p_reg[FLAG_C]};
            res = sum[7:0];
            p_reg[FLAG_C] = sum[8];
            p_reg[FLAG_V] = ~(a_reg[7] ^ m[7]) & (a_reg[7] ^ res[7]);
            set_zn(res);
            a_reg = res;
            o.may_add_cycle = 1'b1;
         end
         OP_AND: begin
            a_reg = a_reg & r.operand;
            set_zn(a_reg);
            o.may_add_cycle = 1'b1;
         end
         OP_ASL: begin
            res = {r.operand[6:0], 1'b0};
            p_reg[FLAG_C] = r.operand[7];
            set_zn(res);
            if (r.accumulator_mode) begin
               a_reg = res;
            end else begin
               o.mem_write = 1'b1;
               o.mem_address = r.target_address;
               o.mem_data = res;
            end
         end
         OP_BCC: take = !p_reg[FLAG_C];
         OP_BCS: take = p_reg[FLAG_C];
         OP_BEQ: take = p_reg[FLAG_Z];
         OP_BMI: take = p_reg[FLAG_N];
         OP_BNE: take = !p_reg[FLAG_Z];
         OP_BPL: take = !p_reg[FLAG_N];
         OP_BVC: take = !p_reg[FLAG_V];
         OP_BVS: take = p_reg[FLAG_V];
         OP_CLC: p_reg[FLAG_C] = 1'b0;
         OP_CLD: p_reg[FLAG_D] = 1'b0;
         OP_CLI: p_reg[FLAG_I] = 1'b0;
         OP_CLV: p_reg[FLAG_V] = 1'b0;
         OP_SEC: p_reg[FLAG_C] = 1'b1;
         OP_SED: p_reg[FLAG_D] = 1'b1;
         OP_SEI: p_reg[FLAG_I] = 1'b1;
         OP_PHA: begin
            stack_mem[sp_reg] = a_reg;
            sp_reg = sp_reg - 8'd1;
         end
         OP_PLA: begin
            sp_reg = sp_reg + 8'd1;
            a_reg = stack_mem[sp_reg];
            set_zn(a_reg);
         end
         OP_PLP: begin
            sp_reg = sp_reg + 8'd1;
            p_reg = stack_mem[sp_reg];
            p_reg[FLAG_U] = 1'b1;
         end
         OP_STA, OP_STX, OP_STY: begin
            o.mem_write = 1'b1;
            o.mem_address = r.target_address;
            o.mem_data = (r.op == OP_STA) ? a_reg : (r.op == OP_STX) ? x_reg : y_reg;
         end
         OP_TAX: begin
            x_reg = a_reg;
            set_zn(x_reg);
         end
         OP_TAY: begin
            y_reg = a_reg;
            set_zn(y_reg);
         end
         OP_TSX: begin
            x_reg = sp_reg;
            set_zn(x_reg);
         end
         OP_TXA: begin
            a_reg = x_reg;
            set_zn(a_reg);
         end
         OP_TXS: sp_reg = x_reg;
         OP_TYA: begin
            a_reg = y_reg;
            set_zn(a_reg);
         end
         default: ;
      endcase
      if (take) begin
         tgt = r.current_pc + {{8{r.branch_offset[7]}}, r.branch_offset};
         o.extra_cycles = ((tgt & PAGE_MASK) != (r.current_pc & PAGE_MASK)) ? 2'd2 : 2'd1;
         o.next_pc = tgt;
      end
      o.acc_out = a_reg;
      o.x_out = x_reg;
      o.y_out = y_reg;
      o.sp_out = sp_reg;
      o.status_out = p_reg;
      return o;
   endfunction

   function automatic req_type random_instr();
      req_type r;
      r = instr(5'($urandom_range(0, 31)), 8'($urandom), 1'($urandom_range(0, 1)),
                16'($urandom), 8'($urandom), 16'($urandom));
      // bias toward stack traffic so pulls return pushed bytes
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 4))
            0: r.op = OP_PHA;
            1: r.op = OP_PLA;
            2: r.op = OP_PLP;
            3: r.op = OP_TXS;
            default: r.op = OP_TSX;
         endcase
      end
      case ($urandom_range(0, 7))
         0: r.operand = 8'h00;
         1: r.operand = 8'hFF;
         2: r.operand = 8'h7F;
         3: r.operand = 8'h80;
         default: ;
      endcase
      return r;
   endfunction

   // drive one item and return at the edge of its transfer
   task automatic issue(input req_type r, input logic typed, input rsp_type want);
      rsp_type predicted;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = execute_instr(r);
      predicted_regs_q.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   task automatic pace();
      int gap;
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 40);
      end
   endtask

   initial begin
      table_row_type row;
      a_reg = '0;
      x_reg = '0;
      y_reg = '0;
      sp_reg = '0;
      p_reg = '0;
      for (int i = 0; i < 256; i++) stack_mem[i] = '0;

      stim_table.push_back('{instr(OP_NONE, 8'hFF, 1'b1, 16'hFFFF, 8'hFF, 16'hFFFF), 1'b1,
         rsp_type'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF, 1'b0, 16'h0000, 8'h00,
                   2'd0, 1'b0}});
      stim_table.push_back('{instr(OP_ADC, 8'hFF, 1'b0, 16'h0000, 8'h00, 16'h0000), 1'b1,
         rsp_type'{8'hFF, 8'h00, 8'h00, 8'h00, 8'h80, 16'h0000, 1'b0, 16'h0000, 8'h00,
                   2'd0, 1'b1}});
      stim_table.push_back('{instr(OP_ADC, 8'h01, 1'b0, 16'h0000, 8'h00, 16'h0000), 1'b1,
         rsp_type'{8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 16'h0000, 1'b0, 16'h0000, 8'h00,
                   2'd0, 1'b1}});
      stim_table.push_back('{instr(OP_STA, 8'h00, 1'b0, 16'hFFFF, 8'h00, 16'h1234), 1'b1,
         rsp_type'{8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 16'h1234, 1'b1, 16'hFFFF, 8'h00,
                   2'd0, 1'b0}});
      // signed overflow, sbc carry, logic and shifts
      stim_table.push_back('{instr(OP_ADC, 8'h7F, 1'b0, 16'h0000, 8'h00, 16'h0001), 1'b0, '0});
      stim_table.push_back('{instr(OP_SBC, 8'h01, 1'b0, 16'h0000, 8'h00, 16'h0002), 1'b0, '0});
      stim_table.push_back('{instr(OP_SBC, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0003), 1'b0, '0});
      stim_table.push_back('{instr(OP_AND, 8'h0F, 1'b0, 16'h0000, 8'h00, 16'h0004), 1'b0, '0});
      stim_table.push_back('{instr(OP_ASL, 8'h80, 1'b1, 16'h0000, 8'h00, 16'h0005), 1'b0, '0});
      stim_table.push_back('{instr(OP_ASL, 8'hFF, 1'b0, 16'h0100, 8'h00, 16'h0006), 1'b0, '0});
      // branches with page crossings in both directions and pc wrap
      stim_table.push_back('{instr(OP_BCC, 8'h00, 1'b0, 16'h0000, 8'h7F, 16'h00FF), 1'b0, '0});
      stim_table.push_back('{instr(OP_BCS, 8'h00, 1'b0, 16'h0000, 8'h7F, 16'h00F0), 1'b0, '0});
      stim_table.push_back('{instr(OP_BEQ, 8'h00, 1'b0, 16'h0000, 8'h80, 16'h1280), 1'b0, '0});
      stim_table.push_back('{instr(OP_BMI, 8'h00, 1'b0, 16'h0000, 8'h80, 16'h1280), 1'b0, '0});
      stim_table.push_back('{instr(OP_BNE, 8'h00, 1'b0, 16'h0000, 8'h01, 16'hFFFF), 1'b0, '0});
      stim_table.push_back('{instr(OP_BPL, 8'h00, 1'b0, 16'h0000, 8'h80, 16'h0010), 1'b0, '0});
      stim_table.push_back('{instr(OP_BVC, 8'h00, 1'b0, 16'h0000, 8'hFF, 16'h0000), 1'b0, '0});
      stim_table.push_back('{instr(OP_BVS, 8'h00, 1'b0, 16'h0000, 8'h10, 16'h4000), 1'b0, '0});
      stim_table.push_back('{instr(OP_SEC, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0007), 1'b0, '0});
      stim_table.push_back('{instr(OP_SED, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0008), 1'b0, '0});
      stim_table.push_back('{instr(OP_SEI, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0009), 1'b0, '0});
      stim_table.push_back('{instr(OP_CLC, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h000A), 1'b0, '0});
      stim_table.push_back('{instr(OP_CLD, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h000B), 1'b0, '0});
      stim_table.push_back('{instr(OP_CLI, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h000C), 1'b0, '0});
      stim_table.push_back('{instr(OP_CLV, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h000D), 1'b0, '0});
      // push then pull of the same slot, sp wraps below zero
      stim_table.push_back('{instr(OP_PHA, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h000E), 1'b0, '0});
      stim_table.push_back('{instr(OP_PLA, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h000F), 1'b0, '0});
      stim_table.push_back('{instr(OP_PHA, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0010), 1'b0, '0});
      stim_table.push_back('{instr(OP_PLP, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0011), 1'b0, '0});
      stim_table.push_back('{instr(OP_TAX, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0012), 1'b0, '0});
      stim_table.push_back('{instr(OP_TAY, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0013), 1'b0, '0});
      stim_table.push_back('{instr(OP_TSX, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0014), 1'b0, '0});
      stim_table.push_back('{instr(OP_TXS, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0015), 1'b0, '0});
      stim_table.push_back('{instr(OP_TXA, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0016), 1'b0, '0});
      stim_table.push_back('{instr(OP_TYA, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0017), 1'b0, '0});
      // stores into page one stay external
      stim_table.push_back('{instr(OP_STX, 8'h00, 1'b0, 16'h0100, 8'h00, 16'h0018), 1'b0, '0});
      stim_table.push_back('{instr(OP_STY, 8'h00, 1'b0, 16'h01FF, 8'h00, 16'h0019), 1'b0, '0});
      stim_table.push_back('{instr(OP_PLA, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h001A), 1'b0, '0});

      wait (!reset);
      @(posedge clock);
      burst_left = $urandom_range(1, 40);
      foreach (stim_table[i]) begin
         row = stim_table[i];
         issue(row.req, row.typed, row.want);
         pace();
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         issue(random_instr(), 1'b0, '0);
         pace();
      end
      req_valid <= 1'b0;

      while (predicted_regs_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d instructions, checked %0d results in %0d cycles",
               items_sent, results_checked, cycle_count);
      $display("taken branches %0d, memory writes %0d, bad results %0d",
               taken_branches, mem_writes, fail_count);
      if (fail_count == 0) begin
         $display("mos6502_execute_subset: match");
      end else begin
         $display("mos6502_execute_subset: mismatch");
      end
      $finish;
   end

   // receiver stalls follow a mode that changes now and then
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  predicted_regs_q.size());
         $display("mos6502_execute_subset: mismatch");
         $finish;
      end
      if (ready_mode_left <= 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_mode_left = $urandom_range(20, 200);
      end else begin
         ready_mode_left = ready_mode_left - 1;
      end
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= cycle_count[2];
      endcase
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_regs_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result transfer at cycle %0d", cycle_count);
         end else begin
            want = predicted_regs_q.pop_front();
            if (want.extra_cycles != 2'd0) taken_branches++;
            if (want.mem_write) mem_writes++;
            if (rsp_data !== want) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("diff at result %0d, cycle %0d", results_checked, cycle_count);
                  $display("  exp a=%h x=%h y=%h sp=%h p=%h pc=%h w=%b wa=%h wd=%h ex=%0d may=%b",
                           want.acc_out, want.x_out, want.y_out, want.sp_out,
                           want.status_out, want.next_pc, want.mem_write, want.mem_address,
                           want.mem_data, want.extra_cycles, want.may_add_cycle);
                  $display("  got a=%h x=%h y=%h sp=%h p=%h pc=%h w=%b wa=%h wd=%h ex=%0d may=%b",
                           rsp_data.acc_out, rsp_data.x_out, rsp_data.y_out, rsp_data.sp_out,
                           rsp_data.status_out, rsp_data.next_pc, rsp_data.mem_write,
                           rsp_data.mem_address, rsp_data.mem_data, rsp_data.extra_cycles,
                           rsp_data.may_add_cycle);
               end
            end
            results_checked++;
         end
      end
   end

endmodule

`default_nettype wire
